// ----- rtl/dsss_pkg.sv -----
package dsss_pkg;

  localparam int STATE_CNT  = 4;
  localparam int INPUT_CNT  = 4;
  localparam int OUTPUT_CNT = 4;
  localparam int FRAC_BITS  = 16;

  // packed coefficient store layout, row-major
  localparam int OFS_A      = 0;
  localparam int OFS_B      = OFS_A + STATE_CNT * STATE_CNT;
  localparam int OFS_F0     = OFS_B + STATE_CNT * INPUT_CNT;
  localparam int OFS_C      = OFS_F0 + STATE_CNT;
  localparam int OFS_D      = OFS_C + OUTPUT_CNT * STATE_CNT;
  localparam int OFS_Y0     = OFS_D + OUTPUT_CNT * INPUT_CNT;
  localparam int COEF_DEPTH = OFS_Y0 + OUTPUT_CNT;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  localparam int MAX_COLS = (STATE_CNT > INPUT_CNT) ? STATE_CNT : INPUT_CNT;
  localparam int MAX_ROWS = (STATE_CNT > OUTPUT_CNT) ? STATE_CNT : OUTPUT_CNT;
  localparam int XW = (STATE_CNT > 1) ? $clog2(STATE_CNT) : 1;
  localparam int UW = (INPUT_CNT > 1) ? $clog2(INPUT_CNT) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 8;
  localparam int IDX_W       = 3;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 40;

  // offset terms enter the accumulator scaled by 2^FRAC_BITS
  localparam logic signed [WORD_W-1:0] OFS_SCALE = WORD_W'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_COEF   = 2'd1,
    MODE_STATE  = 2'd2
  } mode_t;

  // micro-program counter
  typedef enum logic [2:0] {
    U_IDLE = 3'd0,
    U_OFS  = 3'd1,
    U_MX   = 3'd2,
    U_MU   = 3'd3,
    U_DR1  = 3'd4,
    U_DR2  = 3'd5,
    U_FIN  = 3'd6
  } upc_t;

  // what the step reads from the store, and how the value is used downstream
  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_OFS  = 2'd1,
    RD_X    = 2'd2,
    RD_U    = 2'd3
  } rd_t;

  typedef enum logic [1:0] {
    BR_DISPATCH = 2'd0,
    BR_GO       = 2'd1,
    BR_COL      = 2'd2,
    BR_ROW      = 2'd3
  } br_t;

  typedef struct packed {
    rd_t  rd;
    br_t  br;
    upc_t nxt;
  } ucode_t;

  // control store
  function automatic ucode_t ucode(upc_t pc);
    ucode_t w;
    case (pc)
      U_IDLE:  w = '{rd: RD_NONE, br: BR_DISPATCH, nxt: U_OFS};
      U_OFS:   w = '{rd: RD_OFS,  br: BR_GO,       nxt: U_MX};
      U_MX:    w = '{rd: RD_X,    br: BR_COL,      nxt: U_MU};
      U_MU:    w = '{rd: RD_U,    br: BR_COL,      nxt: U_DR1};
      U_DR1:   w = '{rd: RD_NONE, br: BR_GO,       nxt: U_DR2};
      U_DR2:   w = '{rd: RD_NONE, br: BR_GO,       nxt: U_FIN};
      U_FIN:   w = '{rd: RD_NONE, br: BR_ROW,      nxt: U_OFS};
      default: w = '{rd: RD_NONE, br: BR_GO,       nxt: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/dsss_ram.sv -----
module dsss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 72
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/discrete_state_space_step.sv -----
// Discrete-time affine state-space step, Q16.16 fixed point.
//
// Input channel (in_*): one beat per item. in_tuser carries the mode:
//   sample  - u vector in in_tdata; emits y = C x + D u + y0, then x := A x + B u + f0
//   coef    - writes word_value at word_addr of the packed store A,B,f0,C,D,y0
//   state   - writes word_value into state element word_addr
// Write beats are taken while idle and produce nothing.
// Result channel (out_*): OUTPUT_CNT beats per sample, index order, tlast on the
// last; tuser set if that output or any state row of the same step saturated.
//
// Schedule: one multiply-accumulate unit walks every row; a row runs an offset
// read, one coefficient a cycle, the drain steps U_DR1 and U_DR2, then finish.
// State rows run first, then output rows, so a sample holds in_tready low until
// the last output row finishes; the first result appears when output row zero
// finishes.
// A stalled receiver holds the finishing output row until its register drains;
// the last beat may still wait while the next item is taken.
// Reset (rst_n low, synchronous) zeroes the coefficient store (per-entry valid
// bits), the state vector and all control; no clearing pass is needed.
module discrete_state_space_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // u_0, u_1, u_2, u_3, word_addr, word_value
  input  logic [dsss_pkg::IN_TDATA_W-1:0]   in_tdata,
  // mode
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_index, out_value, zero pad
  output logic [dsss_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tlast,
  // saturated
  output logic                              out_tuser
);

  localparam int NS = dsss_pkg::STATE_CNT;
  localparam int NI = dsss_pkg::INPUT_CNT;
  localparam int NO = dsss_pkg::OUTPUT_CNT;
  localparam int AW = dsss_pkg::COEF_AW;
  localparam int CW = dsss_pkg::CW;
  localparam int RW = dsss_pkg::RW;
  localparam int XW = dsss_pkg::XW;
  localparam int UW = dsss_pkg::UW;
  localparam int W  = dsss_pkg::WORD_W;

  // input fields
  logic [dsss_pkg::ADDR_W-1:0] word_addr;
  logic signed [W-1:0]         word_value;
  logic                        in_acc;

  assign word_addr  = in_tdata[4*W +: dsss_pkg::ADDR_W];
  assign word_value = in_tdata[4*W+dsss_pkg::ADDR_W +: W];
  assign in_acc     = in_tvalid && in_tready;

  // sequencer
  dsss_pkg::upc_t   upc_r, upc_nxt;
  dsss_pkg::ucode_t uc;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CW-1:0]    col_r, col_nxt;
  logic             ph_r, ph_nxt;        // 0: state rows, 1: output rows
  logic             st_sat_r, st_sat_nxt;
  logic             fin_stall, fin_go, row_last, col_last;

  // pipeline tags: tag1 describes the store read data, tag2 the product
  dsss_pkg::rd_t    tag1_r, tag2_r;
  logic [CW-1:0]    idx1_r;
  logic             rd_vld_r;

  logic [dsss_pkg::COEF_DEPTH-1:0] vld_r, vld_nxt;
  logic                            coef_we;
  logic [AW-1:0]                   rd_addr;
  logic [W-1:0]                    rdata;

  logic signed [W-1:0] x_r   [NS];
  logic signed [W-1:0] x_nxt [NS];
  logic signed [W-1:0] xn_r  [NS];
  logic signed [W-1:0] u_r   [NI];

  logic signed [W-1:0]   coef, operand;
  logic signed [2*W-1:0] prod_r, acc_r, sum64, q;
  logic signed [2*W:0]   sum65;
  logic                  add_ovf, row_sat_r, fin_sat;
  logic signed [W-1:0]   y;

  logic                       out_tvalid_r, out_tvalid_nxt;
  logic [dsss_pkg::IDX_W-1:0] out_idx_r;
  logic signed [W-1:0]        out_val_r;
  logic                       out_last_r, out_sat_r;

  assign uc        = dsss_pkg::ucode(upc_r);
  assign in_tready = (upc_r == dsss_pkg::U_IDLE);
  assign fin_stall = ph_r && out_tvalid_r && !out_tready;
  assign row_last  = ph_r ? (row_r == RW'(NO - 1)) : (row_r == RW'(NS - 1));
  assign col_last  = (uc.rd == dsss_pkg::RD_X) ? (col_r == CW'(NS - 1))
                                                : (col_r == CW'(NI - 1));
  assign fin_go    = (uc.br == dsss_pkg::BR_ROW) && !fin_stall;

  // store address for this step
  always_comb begin
    case (uc.rd)
      dsss_pkg::RD_OFS:
        rd_addr = AW'((ph_r ? dsss_pkg::OFS_Y0 : dsss_pkg::OFS_F0) + int'(row_r));
      dsss_pkg::RD_X:
        rd_addr = AW'((ph_r ? dsss_pkg::OFS_C : dsss_pkg::OFS_A)
                      + int'(row_r) * NS + int'(col_r));
      dsss_pkg::RD_U:
        rd_addr = AW'((ph_r ? dsss_pkg::OFS_D : dsss_pkg::OFS_B)
                      + int'(row_r) * NI + int'(col_r));
      default:
        rd_addr = '0;
    endcase
  end

  dsss_ram #(
    .WIDTH (W),
    .DEPTH (dsss_pkg::COEF_DEPTH)
  ) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (word_addr[AW-1:0]),
    .wdata (word_value),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // control next state
  always_comb begin
    upc_nxt        = upc_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    ph_nxt         = ph_r;
    st_sat_nxt     = st_sat_r;
    vld_nxt        = vld_r;
    x_nxt          = x_r;
    coef_we        = 1'b0;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    case (uc.br)
      dsss_pkg::BR_DISPATCH: begin
        if (in_acc) begin
          case (dsss_pkg::mode_t'(in_tuser))
            dsss_pkg::MODE_SAMPLE: begin
              upc_nxt    = uc.nxt;
              row_nxt    = '0;
              col_nxt    = '0;
              ph_nxt     = 1'b0;
              st_sat_nxt = 1'b0;
            end
            dsss_pkg::MODE_COEF: begin
              if (int'(word_addr) < dsss_pkg::COEF_DEPTH) begin
                coef_we                     = 1'b1;
                vld_nxt[word_addr[AW-1:0]]  = 1'b1;
              end
            end
            dsss_pkg::MODE_STATE: begin
              if (int'(word_addr) < NS) begin
                x_nxt[word_addr[XW-1:0]] = word_value;
              end
            end
            default: ;
          endcase
        end
      end
      dsss_pkg::BR_GO: begin
        upc_nxt = uc.nxt;
      end
      dsss_pkg::BR_COL: begin
        if (col_last) begin
          col_nxt = '0;
          upc_nxt = uc.nxt;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      dsss_pkg::BR_ROW: begin
        if (!fin_stall) begin
          if (ph_r) begin
            out_tvalid_nxt = 1'b1;
          end else begin
            st_sat_nxt = st_sat_r || row_sat_r || fin_sat;
          end
          if (!row_last) begin
            row_nxt = row_r + RW'(1);
            upc_nxt = uc.nxt;
          end else if (!ph_r) begin
            ph_nxt  = 1'b1;
            row_nxt = '0;
            upc_nxt = uc.nxt;
          end else begin
            // all outputs done: commit the new state
            x_nxt   = xn_r;
            upc_nxt = dsss_pkg::U_IDLE;
          end
        end
      end
      default: upc_nxt = dsss_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= dsss_pkg::U_IDLE;
      row_r        <= '0;
      col_r        <= '0;
      ph_r         <= 1'b0;
      st_sat_r     <= 1'b0;
      vld_r        <= '0;
      tag1_r       <= dsss_pkg::RD_NONE;
      tag2_r       <= dsss_pkg::RD_NONE;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        x_r[i] <= '0;
      end
    end else begin
      upc_r        <= upc_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      ph_r         <= ph_nxt;
      st_sat_r     <= st_sat_nxt;
      vld_r        <= vld_nxt;
      tag1_r       <= uc.rd;
      tag2_r       <= tag1_r;
      out_tvalid_r <= out_tvalid_nxt;
      x_r          <= x_nxt;
    end
  end

  // stage 1: multiply store word by x, u or the offset scale
  always_comb begin
    coef = rd_vld_r ? rdata : '0;
    case (tag1_r)
      dsss_pkg::RD_OFS: operand = dsss_pkg::OFS_SCALE;
      dsss_pkg::RD_X:   operand = x_r[idx1_r[XW-1:0]];
      dsss_pkg::RD_U:   operand = u_r[idx1_r[UW-1:0]];
      default:          operand = '0;
    endcase
  end

  // stage 2: saturating 64-bit accumulate
  assign sum65   = {acc_r[2*W-1], acc_r} + {prod_r[2*W-1], prod_r};
  assign add_ovf = sum65[2*W] != sum65[2*W-1];
  assign sum64   = add_ovf ? {sum65[2*W], {(2*W-1){~sum65[2*W]}}} : sum65[2*W-1:0];

  // finish: floor shift, clamp to 32 bits
  assign q       = acc_r >>> dsss_pkg::FRAC_BITS;
  assign fin_sat = !((&q[2*W-1:W-1]) || !(|q[2*W-1:W-1]));
  assign y       = fin_sat ? {q[2*W-1], {(W-1){~q[2*W-1]}}} : q[W-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && dsss_pkg::mode_t'(in_tuser) == dsss_pkg::MODE_SAMPLE) begin
      for (int i = 0; i < NI; i++) begin
        u_r[i] <= in_tdata[i*W +: W];
      end
    end
    idx1_r   <= col_r;
    rd_vld_r <= vld_r[rd_addr];
    prod_r   <= coef * operand;
    case (tag2_r)
      dsss_pkg::RD_OFS: begin
        acc_r     <= prod_r;
        row_sat_r <= 1'b0;
      end
      dsss_pkg::RD_X, dsss_pkg::RD_U: begin
        acc_r     <= sum64;
        row_sat_r <= row_sat_r || add_ovf;
      end
      default: ;
    endcase
    if (fin_go && !ph_r) begin
      xn_r[row_r[XW-1:0]] <= y;
    end
    if (fin_go && ph_r) begin
      out_idx_r  <= dsss_pkg::IDX_W'(row_r);
      out_val_r  <= y;
      out_last_r <= row_last;
      out_sat_r  <= row_sat_r || fin_sat || st_sat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(dsss_pkg::OUT_TDATA_W - W - dsss_pkg::IDX_W){1'b0}},
                       out_val_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

  // the pipeline is empty whenever a new item can enter
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (tag1_r == dsss_pkg::RD_NONE) && (tag2_r == dsss_pkg::RD_NONE))
    else $error("pipeline busy while idle");

  // the finish step sees a settled accumulator
  a_fin_settled: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == dsss_pkg::U_FIN) |-> (tag2_r == dsss_pkg::RD_NONE))
    else $error("finish with accumulate in flight");

  // tlast only on the final output element
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> (out_idx_r == dsss_pkg::IDX_W'(NO - 1)))
    else $error("tlast on wrong index");

  // a sample starts with the offset read of state row zero
  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_tuser == dsss_pkg::MODE_SAMPLE) |=>
      (upc_r == dsss_pkg::U_OFS) && !ph_r && (row_r == '0))
    else $error("sample did not start at state row zero");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  // mode value the block has no use for; such beats are dropped silently
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // one expected y beat
  typedef struct {
    logic [dsss_pkg::IDX_W-1:0]         index;
    logic signed [dsss_pkg::WORD_W-1:0] value;
    logic                               last;
    logic                               sat;
  } y_beat_t;

  // Predicts the y beats of each sample step from its own copy of the
  // coefficient store and state vector, and holds them until they arrive.
  class state_space_scoreboard;
    logic signed [dsss_pkg::WORD_W-1:0] coef_words [dsss_pkg::COEF_DEPTH];
    logic signed [dsss_pkg::WORD_W-1:0] state_x [dsss_pkg::STATE_CNT];
    y_beat_t expected_y [$];
    int unsigned errors;

    function new();
      foreach (coef_words[i]) coef_words[i] = '0;
      foreach (state_x[i]) state_x[i] = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_y.size();
    endfunction

    // offset * 2^FRAC_BITS + row(m1) . x + row(m2) . u, 64-bit saturating sum,
    // floor shift, then clamp to 32 bits
    function logic signed [dsss_pkg::WORD_W-1:0] eval_row(
        int offs, int xrow, int urow,
        logic signed [dsss_pkg::WORD_W-1:0] u [dsss_pkg::INPUT_CNT],
        output bit sat);
      logic signed [63:0] acc;
      logic signed [63:0] term;
      logic signed [64:0] wide;
      logic signed [63:0] q;
      sat = 1'b0;
      acc = coef_words[offs];
      acc = acc <<< dsss_pkg::FRAC_BITS;
      for (int j = 0; j < dsss_pkg::STATE_CNT + dsss_pkg::INPUT_CNT; j++) begin
        if (j < dsss_pkg::STATE_CNT)
          term = coef_words[xrow + j] * state_x[j];
        else
          term = coef_words[urow + j - dsss_pkg::STATE_CNT] * u[j - dsss_pkg::STATE_CNT];
        wide = acc + term;
        if (wide[64] != wide[63]) begin
          sat = 1'b1;
          acc = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
          acc = wide[63:0];
        end
      end
      q = acc >>> dsss_pkg::FRAC_BITS;
      if (q > 64'sd2147483647) begin
        sat = 1'b1;
        return 32'sh7fff_ffff;
      end
      if (q < -64'sd2147483648) begin
        sat = 1'b1;
        return 32'sh8000_0000;
      end
      return q[dsss_pkg::WORD_W-1:0];
    endfunction

    function void note_input(logic [1:0] mode, logic [dsss_pkg::IN_TDATA_W-1:0] d);
      logic signed [dsss_pkg::WORD_W-1:0] u [dsss_pkg::INPUT_CNT];
      logic signed [dsss_pkg::WORD_W-1:0] x_next [dsss_pkg::STATE_CNT];
      logic [dsss_pkg::ADDR_W-1:0]        addr;
      logic signed [dsss_pkg::WORD_W-1:0] word;
      bit                                 step_sat;
      bit                                 row_sat;
      y_beat_t                            b;
      addr = d[4*dsss_pkg::WORD_W +: dsss_pkg::ADDR_W];
      word = d[4*dsss_pkg::WORD_W + dsss_pkg::ADDR_W +: dsss_pkg::WORD_W];
      case (mode)
        dsss_pkg::MODE_COEF: begin
          if (addr < dsss_pkg::COEF_DEPTH) coef_words[addr] = word;
        end
        dsss_pkg::MODE_STATE: begin
          if (addr < dsss_pkg::STATE_CNT) state_x[addr] = word;
        end
        dsss_pkg::MODE_SAMPLE: begin
          for (int i = 0; i < dsss_pkg::INPUT_CNT; i++)
            u[i] = d[i*dsss_pkg::WORD_W +: dsss_pkg::WORD_W];
          step_sat = 1'b0;
          // next state from the old x; any saturation flags every beat
          for (int i = 0; i < dsss_pkg::STATE_CNT; i++) begin
            x_next[i] = eval_row(dsss_pkg::OFS_F0 + i, dsss_pkg::OFS_A + i*dsss_pkg::STATE_CNT,
                                 dsss_pkg::OFS_B + i*dsss_pkg::INPUT_CNT, u, row_sat);
            step_sat |= row_sat;
          end
          for (int i = 0; i < dsss_pkg::OUTPUT_CNT; i++) begin
            b.value = eval_row(dsss_pkg::OFS_Y0 + i, dsss_pkg::OFS_C + i*dsss_pkg::STATE_CNT,
                               dsss_pkg::OFS_D + i*dsss_pkg::INPUT_CNT, u, row_sat);
            b.index = dsss_pkg::IDX_W'(i);
            b.last  = (i == dsss_pkg::OUTPUT_CNT - 1);
            b.sat   = row_sat | step_sat;
            expected_y.push_back(b);
          end
          state_x = x_next;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [dsss_pkg::OUT_TDATA_W-1:0] d, logic last,
                               logic sat);
      y_beat_t want;
      if (expected_y.size() == 0) begin
        $error("unexpected y beat: out_index %0d out_value %h", d[dsss_pkg::IDX_W-1:0],
               d[dsss_pkg::IDX_W +: dsss_pkg::WORD_W]);
        errors++;
        return;
      end
      want = expected_y.pop_front();
      if (d[dsss_pkg::IDX_W-1:0] !== want.index) begin
        $error("out_index: expected %0d, actual %0d", want.index,
               d[dsss_pkg::IDX_W-1:0]);
        errors++;
      end
      if (d[dsss_pkg::IDX_W +: dsss_pkg::WORD_W] !== want.value) begin
        $error("out_value: expected %h, actual %h", want.value,
               d[dsss_pkg::IDX_W +: dsss_pkg::WORD_W]);
        errors++;
      end
      if (last !== want.last) begin
        $error("is_last: expected %0b, actual %0b", want.last, last);
        errors++;
      end
      if (sat !== want.sat) begin
        $error("saturated: expected %0b, actual %0b", want.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  // u_0, u_1, u_2, u_3, word_addr, word_value
  logic [dsss_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]                       in_tuser = dsss_pkg::MODE_SAMPLE;   // mode
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [dsss_pkg::OUT_TDATA_W-1:0] out_tdata;   // out_index, out_value, zero pad
  logic                             out_tlast;
  logic                             out_tuser;   // saturated

  int tx_idle_pct = 0;   // chance per cycle that the sender leaves a gap
  int rx_idle_pct = 0;   // chance per cycle that the receiver stalls

  state_space_scoreboard sb = new();

  discrete_state_space_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // Watch both channels at the edge; values seen here are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
    end
  end

  // Receiver. Random stalls, plus one long hold-off after some traffic so the
  // output row backs up and the block stops taking samples.
  always @(posedge clk) begin : receiver
    int rx_beats;
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      rx_beats  = 0;
      hold_left = 0;
      hold_done = 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_beats++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_beats >= 60) begin
        hold_done = 1'b1;
        hold_left = 500;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Random Q16.16 word: mostly within +/- span, sometimes any 32-bit value.
  function automatic logic [dsss_pkg::WORD_W-1:0] rand_word(int wide_pct, int span);
    if ($urandom_range(99) < wide_pct) return $urandom;
    return dsss_pkg::WORD_W'($urandom_range(0, 2*span)) - dsss_pkg::WORD_W'(span);
  endfunction

  function automatic logic [dsss_pkg::IN_TDATA_W-1:0] pack_beat(
      logic [dsss_pkg::WORD_W-1:0] u0, u1, u2, u3,
      logic [dsss_pkg::ADDR_W-1:0] addr,
      logic [dsss_pkg::WORD_W-1:0] value);
    return {value, addr, u3, u2, u1, u0};
  endfunction

  // Offer one beat. Called right after an edge; valid is only dropped when a
  // gap is taken, so a back-to-back beat never sees valid low then high.
  task automatic send_item(logic [1:0] mode, logic [dsss_pkg::IN_TDATA_W-1:0] d);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // unused fields of write beats carry random bits
  task automatic send_sample(logic [dsss_pkg::WORD_W-1:0] u0, u1, u2, u3);
    send_item(dsss_pkg::MODE_SAMPLE,
              pack_beat(u0, u1, u2, u3, dsss_pkg::ADDR_W'($urandom), $urandom));
  endtask

  task automatic send_coef(logic [dsss_pkg::ADDR_W-1:0] addr,
                           logic [dsss_pkg::WORD_W-1:0] value);
    send_item(dsss_pkg::MODE_COEF,
              pack_beat($urandom, $urandom, $urandom, $urandom, addr, value));
  endtask

  task automatic send_state(logic [dsss_pkg::ADDR_W-1:0] idx,
                            logic [dsss_pkg::WORD_W-1:0] value);
    send_item(dsss_pkg::MODE_STATE,
              pack_beat($urandom, $urandom, $urandom, $urandom, idx, value));
  endtask

  // sender goes quiet until every predicted beat is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase 1 idling: light sender gaps, heavy receiver stalls
    tx_idle_pct = 23;
    rx_idle_pct = 84;

    // -- directed --
    // empty store: all zero outputs
    send_sample($urandom, $urandom, $urandom, $urandom);
    // a few coefficients at every section of the store
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_A), 32'h0000_8000);
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_B), 32'h0001_0000);
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_F0 + 2), 32'h7fff_ffff);
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_C), 32'h0001_0000);
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_D + dsss_pkg::INPUT_CNT + 1), 32'h7fff_ffff);
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_Y0 + dsss_pkg::OUTPUT_CNT - 1), 32'h8000_0000);
    // addresses past the store are dropped
    send_coef(dsss_pkg::ADDR_W'(dsss_pkg::COEF_DEPTH), $urandom);
    send_coef(8'hff, $urandom);
    // state writes, in and out of range
    send_state(dsss_pkg::ADDR_W'(dsss_pkg::STATE_CNT - 1), 32'h8000_0000);
    send_state(dsss_pkg::ADDR_W'(dsss_pkg::STATE_CNT), $urandom);
    send_state(8'hff, $urandom);
    // unused mode
    send_item(MODE_UNUSED, pack_beat($urandom, $urandom, $urandom, $urandom,
                                     dsss_pkg::ADDR_W'($urandom), $urandom));
    // D row 2 all most-negative: four 2^62 products overflow the accumulator
    for (int j = 0; j < dsss_pkg::INPUT_CNT; j++)
      send_coef(dsss_pkg::ADDR_W'(dsss_pkg::OFS_D + 2*dsss_pkg::INPUT_CNT + j),
                32'h8000_0000);
    send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    // mixed signs, negative floor rounding
    send_sample(32'h0001_0000, 32'hffff_ffff, 32'h8000_0001, 32'h7fff_ffff);

    // -- random: mostly samples, with coefficient and state updates mixed in --
    for (int n = 0; n < 210; n++) begin
      if (n == 70) begin
        wait_drained();
        tx_idle_pct = 84;
        rx_idle_pct = 23;
      end
      if (n == 140) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 55)
        send_sample(rand_word(20, 32'h10_0000), rand_word(20, 32'h10_0000),
                    rand_word(20, 32'h10_0000), rand_word(20, 32'h10_0000));
      else if (pick < 85)
        send_coef(($urandom_range(9) == 0)
                    ? dsss_pkg::ADDR_W'($urandom_range(255))
                    : dsss_pkg::ADDR_W'($urandom_range(dsss_pkg::COEF_DEPTH - 1)),
                  rand_word(15, 32'h8000));
      else if (pick < 95)
        send_state(($urandom_range(9) == 0)
                     ? dsss_pkg::ADDR_W'($urandom_range(255))
                     : dsss_pkg::ADDR_W'($urandom_range(dsss_pkg::STATE_CNT - 1)),
                   rand_word(20, 32'h4_0000));
      else
        send_item(MODE_UNUSED, pack_beat($urandom, $urandom, $urandom, $urandom,
                                         dsss_pkg::ADDR_W'($urandom), $urandom));
    end

    wait_drained();
    // leave room for anything stray
    repeat (150) @(posedge clk);
    if (sb.errors == 0)
      $display("discrete_state_space_step regression: pass");
    else
      $display("discrete_state_space_step regression: fail");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("discrete_state_space_step regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dsss_pkg.sv
rtl/dsss_ram.sv
rtl/discrete_state_space_step.sv
bench/testbench.sv
